@@ hw/rtl/lbbf_pkg.sv @@
// Shared types, constants and codes for the label bounding box fill fraction block.
package lbbf_pkg;

    localparam int MAX_REGIONS = 256;
    localparam int REGION_BITS = 8;
    localparam int COORD_BITS  = 10;
    localparam int SIZE_BITS   = COORD_BITS + 1;
    localparam int COUNT_BITS  = 30;
    localparam int FRAC_BITS   = 17;
    localparam int VOL_BITS    = 3 * COORD_BITS + 1;
    localparam int QUOT_BITS   = 16;
    localparam int ITER_BITS   = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SIZE_BITS-1:0]  SIZE_LIM  = SIZE_BITS'(1) << COORD_BITS;

    localparam logic [1:0] CMD_VOXEL = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [1:0]             command;
        logic [REGION_BITS-1:0] region;
    } in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] voxel_count;
        logic [SIZE_BITS-1:0]  extent_x;
        logic [SIZE_BITS-1:0]  extent_y;
        logic [SIZE_BITS-1:0]  extent_z;
        logic [FRAC_BITS-1:0]  fill_fraction;
        logic                  seen;
    } out_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [COORD_BITS-1:0] min_x;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] min_y;
        logic [COORD_BITS-1:0] max_y;
        logic [COORD_BITS-1:0] min_z;
        logic [COORD_BITS-1:0] max_z;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic vox_wr;
        logic clear;
        logic ext_ld;
        logic mul1;
        logic mul2;
        logic div_init;
        logic div_step;
        logic out_ld;
    } ctrl_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

endpackage

@@ hw/rtl/lbbf_ctrl.sv @@
// Controller state machine sequencing voxel updates, queries and clears.
module lbbf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic [1:0]     s_command,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  lbbf_pkg::stat_t stat,
    output lbbf_pkg::ctrl_t ctrl
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_VOXW  = 3'd1;
    localparam logic [2:0] ST_QEXT  = 3'd2;
    localparam logic [2:0] ST_QMUL1 = 3'd3;
    localparam logic [2:0] ST_QMUL2 = 3'd4;
    localparam logic [2:0] ST_QDINI = 3'd5;
    localparam logic [2:0] ST_QDIV  = 3'd6;
    localparam logic [2:0] ST_QOUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctrl         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        lbbf_pkg::CMD_VOXEL: begin
                            ctrl.rd_en = 1'b1;
                            state_next = ST_VOXW;
                        end
                        lbbf_pkg::CMD_QUERY: begin
                            ctrl.rd_en = 1'b1;
                            state_next = ST_QEXT;
                        end
                        lbbf_pkg::CMD_CLEAR: ctrl.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_VOXW: begin
                ctrl.vox_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_QEXT: begin
                ctrl.ext_ld = 1'b1;
                state_next  = ST_QMUL1;
            end
            ST_QMUL1: begin
                ctrl.mul1  = 1'b1;
                state_next = ST_QMUL2;
            end
            ST_QMUL2: begin
                ctrl.mul2  = 1'b1;
                state_next = ST_QDINI;
            end
            ST_QDINI: begin
                ctrl.div_init = 1'b1;
                state_next    = ST_QDIV;
            end
            ST_QDIV: begin
                if (stat.div_done) begin
                    state_next = ST_QOUT;
                end else begin
                    ctrl.div_step = 1'b1;
                end
            end
            ST_QOUT: begin
                if (!m_valid_reg || m_ready) begin
                    ctrl.out_ld  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hw/rtl/lbbf_dp.sv @@
// Datapath: region table, raster position counter, box volume and fraction divider.
module lbbf_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [lbbf_pkg::SIZE_BITS-1:0]    cfg_wdata,
    input  logic [lbbf_pkg::REGION_BITS-1:0]  s_region,
    input  lbbf_pkg::ctrl_t                   ctrl,
    output lbbf_pkg::stat_t                   stat,
    output lbbf_pkg::out_t                    m_data
);

    localparam int CB = lbbf_pkg::COORD_BITS;
    localparam int SB = lbbf_pkg::SIZE_BITS;
    localparam int VB = lbbf_pkg::VOL_BITS;

    lbbf_pkg::entry_t mem [lbbf_pkg::MAX_REGIONS];
    lbbf_pkg::entry_t rd_data_reg, ent;
    lbbf_pkg::entry_t wr_ent;
    lbbf_pkg::out_t   out_reg;

    logic [lbbf_pkg::MAX_REGIONS-1:0]   valid_reg;
    logic                               rd_valid_reg;
    logic [lbbf_pkg::REGION_BITS-1:0]   addr_reg;
    logic [SB-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [SB-1:0] eff_x, eff_y, eff_z;
    logic [CB-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [SB-1:0] inc_x, inc_y, inc_z;
    logic [SB-1:0] ex_reg, ey_reg, ez_reg;
    logic          seen_reg;
    logic [lbbf_pkg::COUNT_BITS-1:0] count_reg;
    logic [2*SB-1:0] prod1_reg;
    logic [3*SB-1:0] prod2;
    logic [VB-1:0]   vol_reg;
    logic [VB-1:0]   rem_reg, rem2;
    logic [lbbf_pkg::FRAC_BITS-1:0] frac_reg;
    logic [lbbf_pkg::ITER_BITS-1:0] iter_reg;

    function automatic logic [SB-1:0] eff_size(input logic [SB-1:0] v);
        if (v == '0) begin
            return SB'(1);
        end else if (v > lbbf_pkg::SIZE_LIM) begin
            return lbbf_pkg::SIZE_LIM;
        end
        return v;
    endfunction

    assign eff_x = eff_size(size_x_reg);
    assign eff_y = eff_size(size_y_reg);
    assign eff_z = eff_size(size_z_reg);
    assign inc_x = {1'b0, pos_x_reg} + SB'(1);
    assign inc_y = {1'b0, pos_y_reg} + SB'(1);
    assign inc_z = {1'b0, pos_z_reg} + SB'(1);

    always_comb begin
        if (rd_valid_reg) begin
            ent = rd_data_reg;
        end else begin
            ent       = '0;
            ent.min_x = '1;
            ent.min_y = '1;
            ent.min_z = '1;
        end
        wr_ent       = ent;
        wr_ent.count = (ent.count < lbbf_pkg::COUNT_MAX) ? ent.count + 1'b1 : ent.count;
        wr_ent.min_x = (pos_x_reg < ent.min_x) ? pos_x_reg : ent.min_x;
        wr_ent.max_x = (pos_x_reg > ent.max_x) ? pos_x_reg : ent.max_x;
        wr_ent.min_y = (pos_y_reg < ent.min_y) ? pos_y_reg : ent.min_y;
        wr_ent.max_y = (pos_y_reg > ent.max_y) ? pos_y_reg : ent.max_y;
        wr_ent.min_z = (pos_z_reg < ent.min_z) ? pos_z_reg : ent.min_z;
        wr_ent.max_z = (pos_z_reg > ent.max_z) ? pos_z_reg : ent.max_z;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[s_region];
            addr_reg    <= s_region;
        end
        if (ctrl.vox_wr) begin
            mem[addr_reg] <= wr_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            size_x_reg   <= SB'(1024);
            size_y_reg   <= SB'(1024);
            size_z_reg   <= SB'(1);
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    lbbf_pkg::REG_SIZE_X: size_x_reg <= cfg_wdata;
                    lbbf_pkg::REG_SIZE_Y: size_y_reg <= cfg_wdata;
                    lbbf_pkg::REG_SIZE_Z: size_z_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (ctrl.rd_en) begin
                rd_valid_reg <= valid_reg[s_region];
            end
            if (ctrl.clear) begin
                valid_reg <= '0;
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
            end else if (ctrl.vox_wr) begin
                valid_reg[addr_reg] <= 1'b1;
                if (inc_x >= eff_x) begin
                    pos_x_reg <= '0;
                    if (inc_y >= eff_y) begin
                        pos_y_reg <= '0;
                        pos_z_reg <= (inc_z >= eff_z) ? '0 : inc_z[CB-1:0];
                    end else begin
                        pos_y_reg <= inc_y[CB-1:0];
                    end
                end else begin
                    pos_x_reg <= inc_x[CB-1:0];
                end
            end
        end
    end

    assign prod2 = prod1_reg * {{SB{1'b0}}, ez_reg};
    assign rem2  = {rem_reg[VB-2:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (ctrl.ext_ld) begin
            seen_reg  <= rd_valid_reg && (addr_reg != '0) && (ent.count != '0);
            count_reg <= ent.count;
            ex_reg    <= {1'b0, ent.max_x} - {1'b0, ent.min_x} + SB'(1);
            ey_reg    <= {1'b0, ent.max_y} - {1'b0, ent.min_y} + SB'(1);
            ez_reg    <= {1'b0, ent.max_z} - {1'b0, ent.min_z} + SB'(1);
        end
        if (ctrl.mul1) begin
            prod1_reg <= {{SB{1'b0}}, ex_reg} * {{SB{1'b0}}, ey_reg};
        end
        if (ctrl.mul2) begin
            vol_reg <= prod2[VB-1:0];
        end
        if (ctrl.div_init) begin
            rem_reg <= VB'(count_reg);
            if (VB'(count_reg) >= vol_reg) begin
                frac_reg <= lbbf_pkg::FRAC_BITS'(1) << lbbf_pkg::QUOT_BITS;
                iter_reg <= '0;
            end else begin
                frac_reg <= '0;
                iter_reg <= lbbf_pkg::ITER_BITS'(lbbf_pkg::QUOT_BITS);
            end
        end else if (ctrl.div_step) begin
            if (rem2 >= vol_reg) begin
                rem_reg  <= rem2 - vol_reg;
                frac_reg <= {frac_reg[lbbf_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= rem2;
                frac_reg <= {frac_reg[lbbf_pkg::FRAC_BITS-2:0], 1'b0};
            end
            iter_reg <= iter_reg - 1'b1;
        end
        if (ctrl.out_ld) begin
            if (seen_reg) begin
                out_reg.voxel_count   <= count_reg;
                out_reg.extent_x      <= ex_reg;
                out_reg.extent_y      <= ey_reg;
                out_reg.extent_z      <= ez_reg;
                out_reg.fill_fraction <= frac_reg;
                out_reg.seen          <= 1'b1;
            end else begin
                out_reg <= '0;
            end
        end
    end

    assign stat.div_done = (iter_reg == '0);
    assign m_data        = out_reg;

endmodule

@@ hw/rtl/label_bounding_box_fill_fraction_core.sv @@
// Top level of the per-label bounding box fill fraction block.
// Items enter on the s_ channel (valid/ready); a transfer carries a command and a region.
// A voxel command updates the region's count and box at the internal raster position,
// then advances the position, by a read-modify-write of the table memory.
// A query reads the table, forms the box volume with two registered multiplies and
// runs a 16-step restoring divider, one quotient bit per cycle; its result is offered
// on the m_ channel; the divider is skipped when the count reaches the box volume, and
// no new item is taken until the result has entered the output register.
// A clear empties the table and the position at once. The user must write sizes through
// cfg_wr_en, cfg_index and cfg_wdata only while idle; the block does not enforce this.
// Reset restores the default sizes, empties the table and zeroes the position.
// A query result is held in the output register until the receiver takes it;
// while the receiver stalls, further voxels and clears are still accepted, and a
// second query waits to finish until the output register is free.
module label_bounding_box_fill_fraction_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [lbbf_pkg::SIZE_BITS-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lbbf_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lbbf_pkg::out_t                 m_data
);

    lbbf_pkg::ctrl_t ctrl;
    lbbf_pkg::stat_t stat;

    lbbf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lbbf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_region  (s_data.region),
        .ctrl      (ctrl),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule
